>>> src/spi_pool_allocator_assert.svh
// Assertion macros for the identifier pool allocator.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef SPI_POOL_ALLOCATOR_ASSERT_SVH
`define SPI_POOL_ALLOCATOR_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define SPA_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define SPA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> src/spa_pkg.sv
// Shared types and constants of the identifier pool allocator.
// No dependencies; every other file but the assertion header uses this package.
package spa_pkg;

  localparam int unsigned POOL_SIZE = 1024;
  localparam int unsigned SLOT_W    = $clog2(POOL_SIZE);
  localparam int unsigned CNT_W     = $clog2(POOL_SIZE + 1);
  localparam int unsigned ID_W      = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LOWER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ACT_ANY     = 2'd0,
    ACT_NAMED   = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_RANGE  = 3'd1,
    ST_TAKEN  = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_DOUBLE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MEM_RD,
    S_EVAL,
    S_ANY_CHK,
    S_ANY_NXT,
    S_UL_W1,
    S_UL_W2,
    S_AP_W1,
    S_AP_W2,
    S_DONE
  } state_e;

  typedef struct packed {
    action_e         action;
    logic [ID_W-1:0] ident;
    logic [ID_W-1:0] reserved_a;
    logic [ID_W-1:0] reserved_b;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  granted;
    status_e          status;
    logic [CNT_W-1:0] free_count;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0] lo;
    logic [ID_W-1:0] hi;
  } bounds_t;

  typedef struct packed {
    logic              re;
    logic              we_next;
    logic              we_prev;
    logic [SLOT_W-1:0] addr;
    logic [SLOT_W-1:0] wdata;
  } link_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] nxt;
    logic [SLOT_W-1:0] prv;
  } link_rd_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic              wdata;
  } free_req_t;

endpackage

>>> src/spa_link_ram.sv
// Link memory: next and prev pointer of every slot, one address port.
// Depends on spa_pkg.
module spa_link_ram (
  input  logic              clk_i,
  input  spa_pkg::link_req_t req_i,
  output spa_pkg::link_rd_t  rd_o
);

  logic [spa_pkg::SLOT_W-1:0] next_mem [spa_pkg::POOL_SIZE];
  logic [spa_pkg::SLOT_W-1:0] prev_mem [spa_pkg::POOL_SIZE];
  spa_pkg::link_rd_t          rd_q;

  // Read data is held until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.we_next) begin
      next_mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.we_prev) begin
      prev_mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q.nxt <= next_mem[req_i.addr];
      rd_q.prv <= prev_mem[req_i.addr];
    end
  end

  assign rd_o = rd_q;

endmodule

>>> src/spa_free_ram.sv
// Free flag memory: one bit per slot, set while the slot is on the free list.
// Depends on spa_pkg.
module spa_free_ram (
  input  logic               clk_i,
  input  spa_pkg::free_req_t req_i,
  output logic               rd_o
);

  logic free_mem [spa_pkg::POOL_SIZE];
  logic rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      free_mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= free_mem[req_i.addr];
    end
  end

  assign rd_o = rd_q;

endmodule

>>> src/spa_bounds.sv
// Bound registers and the two-stage pipeline that derives the effective range.
// Depends on spa_pkg.
module spa_bounds (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [spa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [spa_pkg::ID_W-1:0]      cfg_data_i,
  output logic                          cfg_clear_o,
  output spa_pkg::bounds_t              bounds_o
);

  logic [spa_pkg::ID_W-1:0] lower_q, lower_d;
  logic [spa_pkg::ID_W-1:0] upper_q, upper_d;
  logic [spa_pkg::ID_W-1:0] lo1_q, lo1_d, hi1_q, hi1_d;
  spa_pkg::bounds_t         eff_q, eff_d;
  logic                     wr;
  logic [spa_pkg::ID_W-1:0] span;

  assign cfg_ready_o = 1'b1;
  assign wr = cfg_valid_i && cfg_ready_o;

  always_comb begin
    lower_d     = lower_q;
    upper_d     = upper_q;
    cfg_clear_o = 1'b0;
    if (wr && cfg_index_i == spa_pkg::REG_LOWER) begin
      lower_d     = cfg_data_i;
      cfg_clear_o = 1'b1;
    end
    if (wr && cfg_index_i == spa_pkg::REG_UPPER) begin
      upper_d     = cfg_data_i;
      cfg_clear_o = 1'b1;
    end
  end

  // Stage one: order the bounds and keep identifier zero out.
  always_comb begin
    if (lower_q > upper_q) begin
      lo1_d = upper_q;
      hi1_d = lower_q;
    end else begin
      lo1_d = lower_q;
      hi1_d = upper_q;
    end
    if (lo1_d == '0) begin
      lo1_d = spa_pkg::ID_W'(1);
    end
    if (hi1_d < lo1_d) begin
      hi1_d = lo1_d;
    end
  end

  // Stage two: clip the range to the pool size.
  always_comb begin
    span     = hi1_q - lo1_q;
    eff_d.lo = lo1_q;
    eff_d.hi = hi1_q;
    if (span >= spa_pkg::ID_W'(spa_pkg::POOL_SIZE)) begin
      eff_d.hi = lo1_q + spa_pkg::ID_W'(spa_pkg::POOL_SIZE - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= spa_pkg::ID_W'(1);
      upper_q <= spa_pkg::ID_W'(1024);
      lo1_q   <= '0;
      hi1_q   <= '0;
      eff_q   <= '0;
    end else begin
      lower_q <= lower_d;
      upper_q <= upper_d;
      lo1_q   <= lo1_d;
      hi1_q   <= hi1_d;
      eff_q   <= eff_d;
    end
  end

  assign bounds_o = eff_q;

endmodule

>>> src/spa_ctrl.sv
// Sequencer of the allocator: list head, tail and count, the clearing pass,
// the read-modify-write steps on both memories and the result register.
// Depends on spa_pkg and spi_pool_allocator_assert.svh.
`include "spi_pool_allocator_assert.svh"

module spa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  spa_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output spa_pkg::out_item_t  out_item_o,
  input  logic                cfg_clear_i,
  input  spa_pkg::bounds_t    bounds_i,
  output spa_pkg::link_req_t  link_req_o,
  input  spa_pkg::link_rd_t   link_rd_i,
  output spa_pkg::free_req_t  free_req_o,
  input  logic                free_rd_i
);

  spa_pkg::state_e            state_q, state_d;
  spa_pkg::in_item_t          item_q;
  logic [spa_pkg::SLOT_W-1:0] slot_q, head_q, tail_q, clr_idx_q;
  logic [spa_pkg::CNT_W-1:0]  count_q, walk_q, count_dec;
  logic [spa_pkg::ID_W-1:0]   granted_q, cand_id, ident_off;
  spa_pkg::status_e           status_q;
  spa_pkg::out_item_t         out_q;
  logic                       out_valid_q, clr_q;
  logic                       in_range, cand_ok, out_free;

  assign cand_id   = bounds_i.lo + spa_pkg::ID_W'(slot_q);
  assign cand_ok   = (cand_id != item_q.reserved_a) && (cand_id != item_q.reserved_b);
  assign ident_off = item_q.ident - bounds_i.lo;
  assign in_range  = (item_q.ident >= bounds_i.lo) && (item_q.ident <= bounds_i.hi);
  assign count_dec = count_q - spa_pkg::CNT_W'(1);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spa_pkg::S_IDLE:    if (in_valid_i && !in_stall_o) state_d = spa_pkg::S_DECODE;
      spa_pkg::S_DECODE: begin
        unique case (item_q.action)
          spa_pkg::ACT_ANY: state_d = spa_pkg::S_ANY_CHK;
          spa_pkg::ACT_NAMED,
          spa_pkg::ACT_RELEASE: state_d = in_range ? spa_pkg::S_MEM_RD : spa_pkg::S_DONE;
          default: state_d = spa_pkg::S_DONE;
        endcase
      end
      spa_pkg::S_MEM_RD:  state_d = spa_pkg::S_EVAL;
      spa_pkg::S_EVAL: begin
        if (item_q.action == spa_pkg::ACT_NAMED) begin
          state_d = free_rd_i ? spa_pkg::S_UL_W1 : spa_pkg::S_DONE;
        end else begin
          state_d = free_rd_i ? spa_pkg::S_DONE : spa_pkg::S_AP_W1;
        end
      end
      spa_pkg::S_ANY_CHK: begin
        priority if (walk_q == count_q) state_d = spa_pkg::S_DONE;
        else if (cand_ok)               state_d = spa_pkg::S_UL_W1;
        else                            state_d = spa_pkg::S_ANY_NXT;
      end
      spa_pkg::S_ANY_NXT: state_d = spa_pkg::S_ANY_CHK;
      spa_pkg::S_UL_W1:   state_d = spa_pkg::S_UL_W2;
      spa_pkg::S_UL_W2:   state_d = spa_pkg::S_DONE;
      spa_pkg::S_AP_W1:   state_d = spa_pkg::S_AP_W2;
      spa_pkg::S_AP_W2:   state_d = spa_pkg::S_DONE;
      spa_pkg::S_DONE:    if (out_free) state_d = spa_pkg::S_IDLE;
      default:            state_d = spa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != spa_pkg::S_IDLE) || clr_q;
    link_req_o = '0;
    free_req_o = '0;
    link_req_o.addr = slot_q;
    free_req_o.addr = slot_q;
    unique case (state_q)
      spa_pkg::S_MEM_RD: begin
        link_req_o.re = 1'b1;
        free_req_o.re = 1'b1;
      end
      spa_pkg::S_ANY_CHK: link_req_o.re = (walk_q != count_q);
      spa_pkg::S_UL_W1: begin
        link_req_o.we_next = (slot_q != head_q);
        link_req_o.addr    = link_rd_i.prv;
        link_req_o.wdata   = link_rd_i.nxt;
      end
      spa_pkg::S_UL_W2: begin
        link_req_o.we_prev = (slot_q != tail_q);
        link_req_o.addr    = link_rd_i.nxt;
        link_req_o.wdata   = link_rd_i.prv;
        free_req_o.we      = 1'b1;
        free_req_o.wdata   = 1'b0;
      end
      spa_pkg::S_AP_W1: begin
        link_req_o.we_next = (count_q != '0);
        link_req_o.addr    = tail_q;
        link_req_o.wdata   = slot_q;
      end
      spa_pkg::S_AP_W2: begin
        link_req_o.we_prev = (count_q != '0);
        link_req_o.wdata   = tail_q;
        free_req_o.we      = 1'b1;
        free_req_o.wdata   = 1'b1;
      end
      default: ;
    endcase
    if (clr_q) begin
      free_req_o.we    = 1'b1;
      free_req_o.addr  = clr_idx_q;
      free_req_o.wdata = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == spa_pkg::S_IDLE) begin
      item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spa_pkg::S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      clr_q       <= 1'b1;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
      slot_q      <= '0;
      walk_q      <= '0;
      granted_q   <= '0;
      status_q    <= spa_pkg::ST_OK;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        spa_pkg::S_DECODE: begin
          granted_q <= '0;
          status_q  <= spa_pkg::ST_RANGE;
          slot_q    <= ident_off[spa_pkg::SLOT_W-1:0];
          walk_q    <= '0;
          if (item_q.action == spa_pkg::ACT_ANY) begin
            slot_q <= head_q;
          end
        end
        spa_pkg::S_EVAL: begin
          status_q <= (item_q.action == spa_pkg::ACT_NAMED) ? spa_pkg::ST_TAKEN
                                                             : spa_pkg::ST_DOUBLE;
        end
        spa_pkg::S_ANY_CHK: begin
          status_q <= spa_pkg::ST_EMPTY;
        end
        spa_pkg::S_ANY_NXT: begin
          slot_q <= link_rd_i.nxt;
          walk_q <= walk_q + spa_pkg::CNT_W'(1);
        end
        spa_pkg::S_UL_W1: begin
          if (slot_q == head_q) begin
            head_q <= link_rd_i.nxt;
          end
        end
        spa_pkg::S_UL_W2: begin
          if (slot_q == tail_q) begin
            tail_q <= link_rd_i.prv;
          end
          if (count_q != '0) begin
            count_q <= count_dec;
          end
          if (count_q == '0 || count_dec == '0) begin
            head_q <= '0;
            tail_q <= '0;
          end
          granted_q <= cand_id;
          status_q  <= spa_pkg::ST_OK;
        end
        spa_pkg::S_AP_W1: begin
          if (count_q == '0) begin
            head_q <= slot_q;
          end
        end
        spa_pkg::S_AP_W2: begin
          tail_q    <= slot_q;
          count_q   <= count_q + spa_pkg::CNT_W'(1);
          granted_q <= item_q.ident;
          status_q  <= spa_pkg::ST_OK;
        end
        spa_pkg::S_DONE: begin
          if (out_free) begin
            out_valid_q      <= 1'b1;
            out_q.granted    <= granted_q;
            out_q.status     <= status_q;
            out_q.free_count <= count_q;
          end
        end
        default: ;
      endcase
      // The clearing pass sweeps the free flags; a bound write restarts it.
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + spa_pkg::SLOT_W'(1);
        if (clr_idx_q == spa_pkg::SLOT_W'(spa_pkg::POOL_SIZE - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (cfg_clear_i) begin
        clr_q     <= 1'b1;
        clr_idx_q <= '0;
        head_q    <= '0;
        tail_q    <= '0;
        count_q   <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `SPA_ASSERT_HOLDS(a_count_in_pool, count_q <= spa_pkg::CNT_W'(spa_pkg::POOL_SIZE), "free count above pool size")
  `SPA_ASSERT_IMPLIES(a_empty_list_ends, (state_q == spa_pkg::S_IDLE) && (count_q == '0), (head_q == '0) && (tail_q == '0), "empty list keeps stale ends")
  `SPA_ASSERT_IMPLIES(a_unlink_nonempty, state_q == spa_pkg::S_UL_W2, count_q != '0, "unlink from an empty list")
  `SPA_ASSERT_IMPLIES(a_result_from_done, $rose(out_valid_q), $past(state_q) == spa_pkg::S_DONE, "result loaded outside the done step")

endmodule

>>> src/spi_pool_allocator.sv
// Top level of the identifier pool allocator.
// Depends on spa_pkg, spa_bounds, spa_ctrl, spa_link_ram and spa_free_ram.
//
// The block hands out identifiers between an effective lower and upper bound
// (bounds swapped when reversed, zero lifted to one, range clipped to the pool
// size) from a doubly linked free list held in a link memory, with a separate
// one-bit memory marking which slots are free. After reset, and after every
// bound write, the list is empty and every identifier counts as taken; software
// fills the pool by releasing identifiers in the order it wants them handed
// out. A clearing pass sweeps the free flags after reset and after each bound
// write, and no item is accepted until it finishes. Each item gives exactly
// one result item. The block works on one item at a time: it does not accept
// a new item until the result of the last one is loaded into the result
// register. Allocate-any walks the free list from its head and steps past
// every entry that holds a reserved value, each step of the walk being one
// dependent read of the link memory. After the result is loaded the block
// returns to its idle state, where it accepts the next item. An item with an
// unknown action is answered as out of range. The next item is accepted while
// the previous result still waits in the output register.
module spi_pool_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  spa_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output spa_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [spa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [spa_pkg::ID_W-1:0]      cfg_data_i
);

  spa_pkg::bounds_t   bounds;
  spa_pkg::link_req_t link_req;
  spa_pkg::link_rd_t  link_rd;
  spa_pkg::free_req_t free_req;
  logic               free_rd;
  logic               cfg_clear;

  // Bound registers and the effective range derived from them.
  spa_bounds u_bounds (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_clear_o (cfg_clear),
    .bounds_o    (bounds)
  );

  // Sequencer: walks and relinks the free list one link memory access at a time.
  spa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_clear_i (cfg_clear),
    .bounds_i    (bounds),
    .link_req_o  (link_req),
    .link_rd_i   (link_rd),
    .free_req_o  (free_req),
    .free_rd_i   (free_rd)
  );

  // Next and prev pointers of every slot.
  spa_link_ram u_link_ram (
    .clk_i (clk_i),
    .req_i (link_req),
    .rd_o  (link_rd)
  );

  // Free flag of every slot.
  spa_free_ram u_free_ram (
    .clk_i (clk_i),
    .req_i (free_req),
    .rd_o  (free_rd)
  );

endmodule

>>> tb/spa_checker.sv
// Checker for the identifier pool allocator: watches the three channels,
// keeps its own copy of the free list and compares every result item.
// Depends on spa_pkg.
`timescale 1ns / 1ps

module spa_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  spa_pkg::in_item_t             in_item_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  spa_pkg::out_item_t            out_item_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [spa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [spa_pkg::ID_W-1:0]      cfg_data_i,
  output int                            pending_o,
  output int                            fail_count_o
);
  import spa_pkg::*;

  logic [ID_W-1:0]   reg_lo, reg_hi;
  logic [SLOT_W-1:0] nxt_mem [POOL_SIZE];
  logic [SLOT_W-1:0] prv_mem [POOL_SIZE];
  bit                on_list [POOL_SIZE];
  logic [SLOT_W-1:0] head, tail;
  logic [CNT_W-1:0]  n_free;
  out_item_t         grant_q[$];

  assign pending_o = grant_q.size();

  function automatic void empty_pool();
    foreach (on_list[i]) on_list[i] = 1'b0;
    head   = '0;
    tail   = '0;
    n_free = '0;
  endfunction

  function automatic void pool_range(output logic [ID_W-1:0] lo, output logic [ID_W-1:0] hi);
    logic [ID_W-1:0] a, b;
    a = reg_lo;
    b = reg_hi;
    if (a > b) begin
      a = reg_hi;
      b = reg_lo;
    end
    if (a == 0) a = 1;
    if (b < a) b = a;
    if ({1'b0, b} - {1'b0, a} >= (ID_W+1)'(POOL_SIZE)) b = a + ID_W'(POOL_SIZE - 1);
    lo = a;
    hi = b;
  endfunction

  function automatic void take_slot(logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] nx, pv;
    nx = nxt_mem[s];
    pv = prv_mem[s];
    if (s == head) head = nx;
    else nxt_mem[pv] = nx;
    if (s == tail) tail = pv;
    else prv_mem[nx] = pv;
    on_list[s] = 1'b0;
    if (n_free > 0) n_free--;
    if (n_free == 0) begin
      head = '0;
      tail = '0;
    end
  endfunction

  function automatic void give_slot(logic [SLOT_W-1:0] s);
    if (n_free == 0) begin
      head = s;
    end else begin
      nxt_mem[tail] = s;
      prv_mem[s] = tail;
    end
    tail = s;
    on_list[s] = 1'b1;
    n_free++;
  endfunction

  function automatic out_item_t grant_for(in_item_t it);
    out_item_t         r;
    logic [ID_W-1:0]   lo, hi, v;
    logic [SLOT_W-1:0] s;
    bit                found;
    r.granted = '0;
    r.status  = ST_OK;
    pool_range(lo, hi);
    found = 1'b0;
    case (it.action)
      ACT_ANY: begin
        s = head;
        for (int k = 0; k < int'(n_free); k++) begin
          v = lo + ID_W'(s);
          if (v != it.reserved_a && v != it.reserved_b) begin
            found = 1'b1;
            break;
          end
          s = nxt_mem[s];
        end
        if (found) begin
          take_slot(s);
          r.granted = lo + ID_W'(s);
        end else begin
          r.status = ST_EMPTY;
        end
      end
      ACT_NAMED, ACT_RELEASE: begin
        if (it.ident < lo || it.ident > hi) begin
          r.status = ST_RANGE;
        end else begin
          s = SLOT_W'(it.ident - lo);
          if (it.action == ACT_NAMED) begin
            if (!on_list[s]) r.status = ST_TAKEN;
            else begin
              take_slot(s);
              r.granted = it.ident;
            end
          end else begin
            if (on_list[s]) r.status = ST_DOUBLE;
            else begin
              give_slot(s);
              r.granted = it.ident;
            end
          end
        end
      end
      default: r.status = ST_RANGE;
    endcase
    r.free_count = n_free;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      reg_lo       = 1;
      reg_hi       = 1024;
      empty_pool();
      grant_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_LOWER) begin
          reg_lo = cfg_data_i;
          empty_pool();
        end else if (cfg_index_i == REG_UPPER) begin
          reg_hi = cfg_data_i;
          empty_pool();
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (grant_q.size() == 0) begin
          $display("%0t: result with nothing expected: granted %0h status %0d count %0d",
                   $time, out_item_i.granted, out_item_i.status, out_item_i.free_count);
          fail_count_o++;
        end else begin
          want = grant_q.pop_front();
          if (want.granted !== out_item_i.granted) begin
            $display("%0t: granted expected %0h actual %0h", $time, want.granted,
                     out_item_i.granted);
            fail_count_o++;
          end
          if (want.status !== out_item_i.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_item_i.status);
            fail_count_o++;
          end
          if (want.free_count !== out_item_i.free_count) begin
            $display("%0t: free_count expected %0d actual %0d", $time, want.free_count,
                     out_item_i.free_count);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) grant_q.push_back(grant_for(in_item_i));
    end
  end

endmodule

>>> tb/tb.sv
// Top of the identifier pool allocator testbench: clock, reset, stimulus
// and verdict. Depends on spa_pkg, spa_checker and spi_pool_allocator.
`timescale 1ns / 1ps

module tb;
  import spa_pkg::*;

  // Action code with no meaning; the block must answer it as out of range.
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PER_PHASE   = 230;

  logic                 clk_i, rst_ni;
  logic                 in_valid, in_stall, out_valid, out_stall;
  in_item_t             in_item;
  out_item_t            out_item;
  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ID_W-1:0]      cfg_data;
  int                   pending, fails, cycles, item_no;
  int                   sender_idle, receiver_idle;
  logic [ID_W-1:0]      cur_lo, cur_hi;

  spi_pool_allocator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  spa_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fails)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The run is cut short if the block stops answering.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver stalls at random in the phases that ask for it.
  always @(posedge clk_i) begin
    out_stall <= (receiver_idle > 0) && ($urandom_range(99) < receiver_idle);
  end

  // The idling pattern changes every 50 items, so that every mix of sender gaps
  // and receiver stalls is seen within each bound setting.
  function automatic void pick_idling(int n);
    case ((n / 50) % 4)
      0: begin sender_idle = 0;  receiver_idle = 0;  end
      1: begin sender_idle = 48; receiver_idle = 0;  end
      2: begin sender_idle = 0;  receiver_idle = 48; end
      default: begin sender_idle = 33; receiver_idle = 33; end
    endcase
  endfunction

  function automatic in_item_t make_item(logic [1:0] act, logic [ID_W-1:0] id,
                                         logic [ID_W-1:0] ra, logic [ID_W-1:0] rb);
    in_item_t it;
    it.action     = action_e'(act);
    it.ident      = id;
    it.reserved_a = ra;
    it.reserved_b = rb;
    return it;
  endfunction

  // Hands one item to the block, leaving valid high so that back-to-back
  // items keep it raised without a second assignment in the same step.
  task automatic send(in_item_t it);
    pick_idling(item_no);
    while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall);
    item_no++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Leaves valid high so that a second write can follow at once; the caller
  // lowers it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Bounds as the block will use them, so that most identifiers land in range.
  task automatic set_bounds(logic [ID_W-1:0] lo_val, logic [ID_W-1:0] hi_val);
    logic [ID_W-1:0] a, b;
    drain();
    write_reg(REG_LOWER, lo_val);
    write_reg(REG_UPPER, hi_val);
    cfg_valid <= 1'b0;
    a = (lo_val > hi_val) ? hi_val : lo_val;
    b = (lo_val > hi_val) ? lo_val : hi_val;
    if (a == 0) a = 1;
    if (b < a) b = a;
    if (b - a > ID_W'(POOL_SIZE - 1)) b = a + ID_W'(POOL_SIZE - 1);
    cur_lo = a;
    cur_hi = b;
  endtask

  // Mostly well-formed traffic within the pool, with reserved values often
  // sitting on the lowest identifiers so that allocate-any has to skip them.
  task automatic random_phase(int n);
    logic [ID_W-1:0] span, id, ra, rb;
    logic [1:0]      act;
    int              r;
    span = cur_hi - cur_lo;
    for (int i = 0; i < n; i++) begin
      r  = $urandom_range(99);
      id = cur_lo + $urandom_range(span);
      ra = ($urandom_range(1)) ? cur_lo + $urandom_range(span < 3 ? span : 3) : $urandom;
      rb = ($urandom_range(1)) ? cur_lo + $urandom_range(span < 3 ? span : 3) : $urandom;
      if (r < 40)      act = ACT_RELEASE;
      else if (r < 65) act = ACT_ANY;
      else if (r < 85) act = ACT_NAMED;
      else if (r < 91) act = ACT_UNKNOWN;
      else begin
        act = $urandom_range(1) ? ACT_NAMED : ACT_RELEASE;
        id  = $urandom;
      end
      send(make_item(act, id, ra, rb));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    cycles        = 0;
    item_no       = 0;
    sender_idle   = 0;
    receiver_idle = 0;
    cur_lo        = 1;
    cur_hi        = 1024;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items on the reset bounds, one to 1024.
    send(make_item(ACT_ANY, 0, 0, 0));                        // empty pool
    send(make_item(ACT_NAMED, 5, 0, 0));                      // taken identifier
    send(make_item(ACT_RELEASE, 1, 0, 0));                    // lowest identifier
    send(make_item(ACT_RELEASE, 1024, 0, 0));                 // highest identifier
    send(make_item(ACT_RELEASE, 2, 0, 0));
    send(make_item(ACT_RELEASE, 0, 0, 0));                    // below the pool
    send(make_item(ACT_RELEASE, 1025, 0, 0));                 // above the pool
    send(make_item(ACT_NAMED, 32'hFFFF_FFFF, 0, 0));
    send(make_item(ACT_RELEASE, 1024, 0, 0));                 // double release
    send(make_item(ACT_ANY, 0, 1, 1024));                     // skips two entries
    send(make_item(ACT_ANY, 0, 1, 1024));                     // only reserved left
    send(make_item(ACT_NAMED, 1024, 0, 0));
    send(make_item(ACT_NAMED, 1024, 0, 0));                   // now taken
    send(make_item(ACT_UNKNOWN, 1, 0, 0));                    // unknown action
    send(make_item(ACT_ANY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(make_item(ACT_RELEASE, 3, 0, 0));
    send(make_item(ACT_NAMED, 1, 0, 0));
    send(make_item(ACT_ANY, 0, 0, 0));
    random_phase(PER_PHASE);

    set_bounds(5, 20);                  // small pool, lots of reuse
    random_phase(PER_PHASE);
    set_bounds(100, 40);                // reversed bounds
    random_phase(PER_PHASE);
    set_bounds(0, 0);                   // zero lower bound: the pool is just one
    random_phase(PER_PHASE);
    set_bounds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(PER_PHASE);
    set_bounds(32'hFFFF_FC00, 32'hFFFF_FFFF);
    random_phase(PER_PHASE);
    set_bounds(1, 32'hFFFF_FFFF);       // oversized range, clipped
    random_phase(PER_PHASE);
    set_bounds(0, 3);
    random_phase(PER_PHASE);

    drain();
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
